// ===== rtl/core/bst_pkg.sv =====
`timescale 1ns / 1ps

package bst_pkg;

   // Record types on the result channel.
   localparam logic [1:0] REC_CONTENT = 2'd0;
   localparam logic [1:0] REC_TOKEN   = 2'd1;
   localparam logic [1:0] REC_ERROR   = 2'd2;

   // Token kinds.
   localparam logic [3:0] KIND_END    = 4'd0;
   localparam logic [3:0] KIND_IDENT  = 4'd1;
   localparam logic [3:0] KIND_FOR    = 4'd2;
   localparam logic [3:0] KIND_IN     = 4'd3;
   localparam logic [3:0] KIND_STRING = 4'd4;
   localparam logic [3:0] KIND_DOT    = 4'd5;
   localparam logic [3:0] KIND_LBRACK = 4'd6;
   localparam logic [3:0] KIND_RBRACK = 4'd7;
   localparam logic [3:0] KIND_LPAREN = 4'd8;
   localparam logic [3:0] KIND_RPAREN = 4'd9;
   localparam logic [3:0] KIND_EQUALS = 4'd10;

   // Error codes.
   localparam logic ERR_CHAR = 1'b0;
   localparam logic ERR_END  = 1'b1;

   // Characters of interest.
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_O  = 8'h6F;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;

   // Depth of the result queue.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   // Lexer modes, one-hot.
   typedef enum logic [8:0] {
      MODE_IDLE  = 9'b000000001,
      MODE_LINE  = 9'b000000010,
      MODE_SLASH = 9'b000000100,
      MODE_BLOCK = 9'b000001000,
      MODE_BSTAR = 9'b000010000,
      MODE_IDENT = 9'b000100000,
      MODE_STR   = 9'b001000000,
      MODE_ESC   = 9'b010000000,
      MODE_HALT  = 9'b100000000
   } mode_type;

   // One result record.
   typedef struct packed {
      logic [1:0]  record_type;
      logic [3:0]  token_kind;
      logic        error_code;
      logic [7:0]  content_byte;
      logic [31:0] token_start;
      logic        last_result;
   } rec_type;

   // Results of one input transaction, handed from the lexer to the queue.
   typedef struct packed {
      logic        push;
      logic [1:0]  count;
      rec_type [1:0] recs;
   } lex_out_type;

   // Keyword tracking state.
   typedef struct packed {
      logic [1:0] len;
      logic [1:0] flags;
   } kw_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
   endfunction

   // Adds one identifier byte to the keyword match state.
   function automatic kw_type kw_add(input kw_type cur, input logic [7:0] c);
      kw_type     nxt;
      logic [7:0] for_ch;
      logic [7:0] in_ch;
      nxt = cur;
      case (cur.len)
         2'd0:    for_ch = CH_LOW_F;
         2'd1:    for_ch = CH_LOW_O;
         2'd2:    for_ch = CH_LOW_R;
         default: for_ch = 8'h00;
      endcase
      in_ch = (cur.len == 2'd0) ? CH_LOW_I : CH_LOW_N;
      if (cur.len == 2'd3 || c != for_ch) begin
         nxt.flags[0] = 1'b0;
      end
      if (cur.len >= 2'd2 || c != in_ch) begin
         nxt.flags[1] = 1'b0;
      end
      if (cur.len != 2'd3) begin
         nxt.len = cur.len + 2'd1;
      end
      return nxt;
   endfunction

   function automatic rec_type make_rec(input logic [1:0] rtype, input logic [3:0] kind,
                                        input logic err, input logic [7:0] data,
                                        input logic [31:0] start);
      rec_type r;
      r.record_type  = rtype;
      r.token_kind   = kind;
      r.error_code   = err;
      r.content_byte = data;
      r.token_start  = start;
      r.last_result  = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/core/build_script_tokenizer.sv =====
`timescale 1ns / 1ps
// A byte accepted is held in the input register and lexed from there once the result
// queue has room; its records are written into the queue, which drives the rsp_ ports.
// Throughput: one byte per cycle while the result queue has room; a byte that yields
// two records is read out one record at a time through the queue's single read port.
// Reset: synchronous, active high; lexer returns to between tokens, offsets to zero,
// and the input register and result queue are emptied.

module build_script_tokenizer #(
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_type,
   output logic [3:0]  rsp_token_kind,
   output logic        rsp_error_code,
   output logic [7:0]  rsp_content_byte,
   output logic [31:0] rsp_token_start,
   output logic        rsp_last_result
);
   import bst_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_char_ff;
   logic        in_eoi_ff;
   logic        item_fire;
   logic        room;
   lex_out_type lex_out;
   rec_type     head;

   // The held transaction is lexed once the queue can take both of its records.
   assign item_fire = in_vld_ff && room;
   assign req_ready = !in_vld_ff || item_fire;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !item_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_byte;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   bst_lexer #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (item_fire),
      .char_byte    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .lex_out      (lex_out)
   );

   bst_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .lex_out   (lex_out),
      .pop       (rsp_ready),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_record_type  = head.record_type;
   assign rsp_token_kind   = head.token_kind;
   assign rsp_error_code   = head.error_code;
   assign rsp_content_byte = head.content_byte;
   assign rsp_token_start  = head.token_start;
   assign rsp_last_result  = head.last_result;

endmodule

// ===== rtl/core/bst_lexer.sv =====
`timescale 1ns / 1ps

module bst_lexer #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_fire,
   input  logic [7:0]           char_byte,
   input  logic                 end_of_input,
   output bst_pkg::lex_out_type lex_out
);
   import bst_pkg::*;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] byte_off_ff, byte_off_in;
   logic [OFFSET_BITS-1:0] start_off_ff, start_off_in;
   kw_type                 kw_ff, kw_in;

   logic [31:0] sat_byte;
   logic [31:0] sat_start;

   // Path taken by a byte seen between tokens.
   mode_type   idle_mode;
   logic       idle_emit;
   rec_type    idle_rec;
   logic       idle_start;
   logic       idle_ident;
   logic [3:0] punct_kind;
   logic [3:0] close_kind;
   kw_type     kw_first;

   logic [1:0]    count;
   rec_type [1:0] recs;

   // Offsets are reported in 32 bits, saturating.
   generate
      if (OFFSET_BITS > 32) begin : g_wide
         assign sat_byte  = (|byte_off_ff[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF
                                                             : byte_off_ff[31:0];
         assign sat_start = (|start_off_ff[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF
                                                              : start_off_ff[31:0];
      end else if (OFFSET_BITS == 32) begin : g_equal
         assign sat_byte  = byte_off_ff;
         assign sat_start = start_off_ff;
      end else begin : g_narrow
         assign sat_byte  = {{(32-OFFSET_BITS){1'b0}}, byte_off_ff};
         assign sat_start = {{(32-OFFSET_BITS){1'b0}}, start_off_ff};
      end
   endgenerate

   // Punctuation decode.
   always_comb begin
      case (char_byte)
         CH_DOT:    punct_kind = KIND_DOT;
         CH_LBRACK: punct_kind = KIND_LBRACK;
         CH_RBRACK: punct_kind = KIND_RBRACK;
         CH_LPAREN: punct_kind = KIND_LPAREN;
         CH_RPAREN: punct_kind = KIND_RPAREN;
         CH_EQUALS: punct_kind = KIND_EQUALS;
         default:   punct_kind = KIND_END;
      endcase
   end

   assign kw_first = kw_add(kw_type'({2'd0, 2'b11}), char_byte);

   // Handling of a byte from the between-tokens state.
   always_comb begin
      idle_mode  = MODE_IDLE;
      idle_emit  = 1'b0;
      idle_start = 1'b0;
      idle_ident = 1'b0;
      idle_rec   = make_rec(REC_TOKEN, punct_kind, ERR_CHAR, 8'h00, sat_byte);
      if (is_space(char_byte)) begin
         idle_mode = MODE_IDLE;
      end else if (char_byte == CH_HASH) begin
         idle_mode = MODE_LINE;
      end else if (char_byte == CH_SLASH) begin
         idle_mode = MODE_SLASH;
      end else if (is_alpha(char_byte)) begin
         idle_mode  = MODE_IDENT;
         idle_start = 1'b1;
         idle_ident = 1'b1;
         idle_emit  = 1'b1;
         idle_rec   = make_rec(REC_CONTENT, KIND_IDENT, ERR_CHAR, char_byte, sat_byte);
      end else if (char_byte == CH_QUOTE) begin
         idle_mode  = MODE_STR;
         idle_start = 1'b1;
      end else if (punct_kind != KIND_END) begin
         idle_emit = 1'b1;
      end else begin
         idle_mode = MODE_HALT;
         idle_emit = 1'b1;
         idle_rec  = make_rec(REC_ERROR, KIND_END, ERR_CHAR, char_byte, sat_byte);
      end
   end

   // Kind of the identifier being closed.
   always_comb begin
      if (kw_ff.flags[0] && kw_ff.len == 2'd3) begin
         close_kind = KIND_FOR;
      end else if (kw_ff.flags[1] && kw_ff.len == 2'd2) begin
         close_kind = KIND_IN;
      end else begin
         close_kind = KIND_IDENT;
      end
   end

   // Mode update and result records for one transaction.
   always_comb begin
      mode_in      = mode_ff;
      byte_off_in  = byte_off_ff;
      start_off_in = start_off_ff;
      kw_in        = kw_ff;
      count        = 2'd0;
      recs[0]      = make_rec(REC_TOKEN, KIND_END, ERR_CHAR, 8'h00, sat_byte);
      recs[1]      = make_rec(REC_TOKEN, KIND_END, ERR_CHAR, 8'h00, sat_byte);

      if (mode_ff != MODE_HALT) begin
         if (end_of_input) begin
            case (mode_ff)
               MODE_IDENT: begin
                  mode_in = MODE_IDLE;
                  count   = 2'd2;
                  recs[0] = make_rec(REC_TOKEN, close_kind, ERR_CHAR, 8'h00, sat_start);
               end
               MODE_SLASH, MODE_BLOCK, MODE_BSTAR, MODE_STR, MODE_ESC: begin
                  mode_in = MODE_HALT;
                  count   = 2'd1;
                  recs[0] = make_rec(REC_ERROR, KIND_END, ERR_END, 8'h00, sat_byte);
               end
               default: begin
                  mode_in = MODE_IDLE;
                  count   = 2'd1;
               end
            endcase
         end else begin
            if (byte_off_ff != OFFSET_MAX) begin
               byte_off_in = byte_off_ff + 1'b1;
            end
            case (mode_ff)
               MODE_LINE: begin
                  if (char_byte == CH_LF) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_SLASH: begin
                  if (char_byte == CH_STAR) begin
                     mode_in = MODE_BLOCK;
                  end else begin
                     mode_in = MODE_HALT;
                     count   = 2'd1;
                     recs[0] = make_rec(REC_ERROR, KIND_END, ERR_CHAR, char_byte, sat_byte);
                  end
               end
               MODE_BLOCK: begin
                  if (char_byte == CH_STAR) begin
                     mode_in = MODE_BSTAR;
                  end
               end
               MODE_BSTAR: begin
                  if (char_byte == CH_SLASH) begin
                     mode_in = MODE_IDLE;
                  end else if (char_byte != CH_STAR) begin
                     mode_in = MODE_BLOCK;
                  end
               end
               MODE_IDENT: begin
                  if (is_ident(char_byte)) begin
                     kw_in   = kw_add(kw_ff, char_byte);
                     count   = 2'd1;
                     recs[0] = make_rec(REC_CONTENT, KIND_IDENT, ERR_CHAR, char_byte,
                                        sat_start);
                  end else begin
                     // Close the identifier, then treat the byte as between tokens.
                     recs[0] = make_rec(REC_TOKEN, close_kind, ERR_CHAR, 8'h00, sat_start);
                     recs[1] = idle_rec;
                     count   = idle_emit ? 2'd2 : 2'd1;
                     mode_in = idle_mode;
                     if (idle_start) begin
                        start_off_in = byte_off_ff;
                     end
                     if (idle_ident) begin
                        kw_in = kw_first;
                     end
                  end
               end
               MODE_STR: begin
                  if (char_byte == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else if (char_byte == CH_QUOTE) begin
                     mode_in = MODE_IDLE;
                     count   = 2'd1;
                     recs[0] = make_rec(REC_TOKEN, KIND_STRING, ERR_CHAR, 8'h00, sat_start);
                  end else begin
                     count   = 2'd1;
                     recs[0] = make_rec(REC_CONTENT, KIND_STRING, ERR_CHAR, char_byte,
                                        sat_start);
                  end
               end
               MODE_ESC: begin
                  mode_in = MODE_STR;
                  count   = 2'd1;
                  recs[0] = make_rec(REC_CONTENT, KIND_STRING, ERR_CHAR, char_byte, sat_start);
               end
               default: begin
                  recs[0] = idle_rec;
                  count   = idle_emit ? 2'd1 : 2'd0;
                  mode_in = idle_mode;
                  if (idle_start) begin
                     start_off_in = byte_off_ff;
                  end
                  if (idle_ident) begin
                     kw_in = kw_first;
                  end
               end
            endcase
         end
      end

      // Mark the final record of this transaction.
      if (count == 2'd1) begin
         recs[0].last_result = 1'b1;
      end else if (count == 2'd2) begin
         recs[1].last_result = 1'b1;
      end
   end

   assign lex_out.push  = item_fire && (count != 2'd0);
   assign lex_out.count = count;
   assign lex_out.recs  = recs;

   // Lexer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         byte_off_ff  <= '0;
         start_off_ff <= '0;
         kw_ff        <= kw_type'({2'd0, 2'b11});
      end else if (item_fire) begin
         mode_ff      <= mode_in;
         byte_off_ff  <= byte_off_in;
         start_off_ff <= start_off_in;
         kw_ff        <= kw_in;
      end
   end

endmodule

// ===== rtl/core/bst_rsp_fifo.sv =====
`timescale 1ns / 1ps

module bst_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  bst_pkg::lex_out_type lex_out,
   input  logic                 pop,
   output logic                 room,
   output logic                 not_empty,
   output bst_pkg::rec_type     head
);
   import bst_pkg::*;

   rec_type                 mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [RSP_CNT_BITS-1:0] push_n;
   logic                    pop_en;

   assign not_empty = (count_ff != '0);
   assign pop_en    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];
   // Room for the largest burst of one transaction.
   assign room      = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));

   assign push_n    = lex_out.push ? RSP_CNT_BITS'(lex_out.count) : '0;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(pop_en);
      count_in  = count_ff + push_n - RSP_CNT_BITS'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage, up to two writes per cycle.
   always_ff @(posedge clock) begin
      if (lex_out.push) begin
         mem_ff[wr_ptr_ff] <= lex_out.recs[0];
         if (lex_out.count == 2'd2) begin
            mem_ff[wr_ptr_ff + 1'b1] <= lex_out.recs[1];
         end
      end
   end

endmodule

// ===== rtl/core/bst_checker.sv =====
`timescale 1ns / 1ps

module bst_protocol_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_record_type,
   input logic [3:0]  rsp_token_kind,
   input logic        rsp_error_code,
   input logic [7:0]  rsp_content_byte,
   input logic [31:0] rsp_token_start,
   input logic        rsp_last_result
);
   import bst_pkg::*;

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result transaction holds its record.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_type) &&
         $stable(rsp_token_kind) && $stable(rsp_content_byte) &&
         $stable(rsp_token_start) && $stable(rsp_last_result))
      else $error("stalled result changed");

   // An error ends the item's results and halts the lexer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_type == REC_ERROR |-> rsp_last_result)
      else $error("error record not last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_record_type == REC_ERROR |=> !rsp_valid)
      else $error("result after error");

   // Content only belongs to identifiers and strings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_type == REC_CONTENT |->
         (rsp_token_kind == KIND_IDENT || rsp_token_kind == KIND_STRING) &&
         rsp_error_code == ERR_CHAR)
      else $error("content record with bad kind");

endmodule

bind build_script_tokenizer bst_protocol_checker u_bst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_record_type  (rsp_record_type),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_error_code   (rsp_error_code),
   .rsp_content_byte (rsp_content_byte),
   .rsp_token_start  (rsp_token_start),
   .rsp_last_result  (rsp_last_result)
);

// ===== tb/bst_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the records of each byte
// transaction and compares every result transaction with the oldest prediction.
module bst_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_record_type,
   input  logic [3:0]  rsp_token_kind,
   input  logic        rsp_error_code,
   input  logic [7:0]  rsp_content_byte,
   input  logic [31:0] rsp_token_start,
   input  logic        rsp_last_result,
   output int          mismatch_count,
   output int          outstanding
);
   import bst_pkg::*;

   localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;

   // Lexer state as the predictor sees it.
   mode_type    lex_state;
   logic [31:0] cur_offset;
   logic [31:0] tok_offset;
   logic [1:0]  word_len;
   logic        for_ok;
   logic        in_ok;

   // Records of the transaction being lexed, and all records still awaited.
   rec_type     step_recs [0:1];
   int          step_count;
   rec_type     awaited_recs [$];

   function automatic logic blank_char(input logic [7:0] c);
      return c inside {CH_SPACE, [8'h09:8'h0D]};
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return letter_char(c) || (c inside {[8'h30:8'h39]}) || c == CH_UNDER;
   endfunction

   task automatic emit(input logic [1:0] rtype, input logic [3:0] kind, input logic err,
                       input logic [7:0] data, input logic [31:0] start);
      rec_type r;
      r.record_type  = rtype;
      r.token_kind   = kind;
      r.error_code   = err;
      r.content_byte = data;
      r.token_start  = start;
      r.last_result  = 1'b0;
      step_recs[step_count] = r;
      step_count++;
   endtask

   // Narrow the keyword candidates with one more identifier byte.
   task automatic word_add(input logic [7:0] c);
      logic [7:0] for_letter;
      logic [7:0] in_letter;
      case (word_len)
         2'd0: begin
            for_letter = CH_LOW_F;
            in_letter  = CH_LOW_I;
         end
         2'd1: begin
            for_letter = CH_LOW_O;
            in_letter  = CH_LOW_N;
         end
         default: begin
            for_letter = CH_LOW_R;
            in_letter  = CH_LOW_N;
         end
      endcase
      if (word_len == 2'd3 || c != for_letter) for_ok = 1'b0;
      if (word_len >= 2'd2 || c != in_letter) in_ok = 1'b0;
      if (word_len != 2'd3) word_len = word_len + 2'd1;
   endtask

   task automatic close_word();
      logic [3:0] kind;
      if (for_ok && word_len == 2'd3) begin
         kind = KIND_FOR;
      end else if (in_ok && word_len == 2'd2) begin
         kind = KIND_IN;
      end else begin
         kind = KIND_IDENT;
      end
      emit(REC_TOKEN, kind, 1'b0, 8'h00, tok_offset);
      lex_state = MODE_IDLE;
   endtask

   // A byte seen between tokens.
   task automatic lex_from_idle(input logic [7:0] c);
      logic [3:0] punct;
      punct = KIND_END;
      if (blank_char(c)) begin
         lex_state = MODE_IDLE;
      end else if (c == CH_HASH) begin
         lex_state = MODE_LINE;
      end else if (c == CH_SLASH) begin
         lex_state = MODE_SLASH;
      end else if (letter_char(c)) begin
         lex_state  = MODE_IDENT;
         tok_offset = cur_offset;
         word_len   = 2'd0;
         for_ok     = 1'b1;
         in_ok      = 1'b1;
         word_add(c);
         emit(REC_CONTENT, KIND_IDENT, 1'b0, c, tok_offset);
      end else if (c == CH_QUOTE) begin
         lex_state  = MODE_STR;
         tok_offset = cur_offset;
      end else begin
         case (c)
            CH_DOT:    punct = KIND_DOT;
            CH_LBRACK: punct = KIND_LBRACK;
            CH_RBRACK: punct = KIND_RBRACK;
            CH_LPAREN: punct = KIND_LPAREN;
            CH_RPAREN: punct = KIND_RPAREN;
            CH_EQUALS: punct = KIND_EQUALS;
            default:   punct = KIND_END;
         endcase
         if (punct != KIND_END) begin
            emit(REC_TOKEN, punct, 1'b0, 8'h00, cur_offset);
         end else begin
            emit(REC_ERROR, KIND_END, ERR_CHAR, c, cur_offset);
            lex_state = MODE_HALT;
         end
      end
   endtask

   // Lex one accepted transaction and queue the records it should produce.
   task automatic lex_step(input logic [7:0] c, input logic eoi);
      step_count = 0;
      if (lex_state != MODE_HALT) begin
         if (eoi) begin
            case (lex_state)
               MODE_IDENT: begin
                  close_word();
                  emit(REC_TOKEN, KIND_END, 1'b0, 8'h00, cur_offset);
               end
               MODE_SLASH, MODE_BLOCK, MODE_BSTAR, MODE_STR, MODE_ESC: begin
                  emit(REC_ERROR, KIND_END, ERR_END, 8'h00, cur_offset);
                  lex_state = MODE_HALT;
               end
               default: begin
                  lex_state = MODE_IDLE;
                  emit(REC_TOKEN, KIND_END, 1'b0, 8'h00, cur_offset);
               end
            endcase
         end else begin
            case (lex_state)
               MODE_LINE: begin
                  if (c == CH_LF) lex_state = MODE_IDLE;
               end
               MODE_SLASH: begin
                  if (c == CH_STAR) begin
                     lex_state = MODE_BLOCK;
                  end else begin
                     emit(REC_ERROR, KIND_END, ERR_CHAR, c, cur_offset);
                     lex_state = MODE_HALT;
                  end
               end
               MODE_BLOCK: begin
                  if (c == CH_STAR) lex_state = MODE_BSTAR;
               end
               MODE_BSTAR: begin
                  if (c == CH_SLASH) begin
                     lex_state = MODE_IDLE;
                  end else if (c != CH_STAR) begin
                     lex_state = MODE_BLOCK;
                  end
               end
               MODE_IDENT: begin
                  if (word_char(c)) begin
                     word_add(c);
                     emit(REC_CONTENT, KIND_IDENT, 1'b0, c, tok_offset);
                  end else begin
                     close_word();
                     lex_from_idle(c);
                  end
               end
               MODE_STR: begin
                  if (c == CH_BSLASH) begin
                     lex_state = MODE_ESC;
                  end else if (c == CH_QUOTE) begin
                     emit(REC_TOKEN, KIND_STRING, 1'b0, 8'h00, tok_offset);
                     lex_state = MODE_IDLE;
                  end else begin
                     emit(REC_CONTENT, KIND_STRING, 1'b0, c, tok_offset);
                  end
               end
               MODE_ESC: begin
                  emit(REC_CONTENT, KIND_STRING, 1'b0, c, tok_offset);
                  lex_state = MODE_STR;
               end
               default: begin
                  lex_state = MODE_IDLE;
                  lex_from_idle(c);
               end
            endcase
            if (cur_offset != OFFSET_TOP) cur_offset = cur_offset + 32'd1;
         end
      end
      if (step_count > 0) step_recs[step_count - 1].last_result = 1'b1;
      for (int i = 0; i < step_count; i++) awaited_recs.push_back(step_recs[i]);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Results are compared before the new byte is lexed; a byte's results never return in the cycle it is accepted.
   always @(posedge clock) begin : monitor
      rec_type want;
      if (reset) begin
         lex_state      = MODE_IDLE;
         cur_offset     = 32'd0;
         tok_offset     = 32'd0;
         word_len       = 2'd0;
         for_ok         = 1'b1;
         in_ok          = 1'b1;
         mismatch_count = 0;
         awaited_recs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_recs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual type %0d kind %0d start %0d",
                        $time, rsp_record_type, rsp_token_kind, rsp_token_start);
               mismatch_count++;
            end else begin
               want = awaited_recs.pop_front();
               check_field("record_type", want.record_type, rsp_record_type);
               check_field("token_kind", want.token_kind, rsp_token_kind);
               check_field("error_code", want.error_code, rsp_error_code);
               check_field("content_byte", want.content_byte, rsp_content_byte);
               check_field("token_start", want.token_start, rsp_token_start);
               check_field("last_result", want.last_result, rsp_last_result);
            end
         end
         if (req_valid && req_ready) lex_step(req_char_byte, req_end_of_input);
      end
      outstanding <= awaited_recs.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Drives a build script at the tokenizer one byte per transaction, throttles the
// result side, and reports the verdict from the checker's mismatch count.
module tb_top;
   import bst_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;
   localparam int GAP_PERCENT  = 7;
   localparam int QUIET_FROM   = 700;
   localparam int QUIET_TO     = 1000;
   localparam int HOLD_FROM    = 300;
   localparam int HOLD_LEN     = 90;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_record_type;
   logic [3:0]  rsp_token_kind;
   logic        rsp_error_code;
   logic [7:0]  rsp_content_byte;
   logic [31:0] rsp_token_start;
   logic        rsp_last_result;

   int          mismatch_count;
   int          outstanding;
   int          cyc = 0;
   int          items_sent = 0;

   // Identifiers close to the keywords, to exercise the keyword match.
   string       word_pool [0:7] = '{"for", "in", "fo", "f", "i", "inn", "form", "fr"};

   build_script_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_type  (rsp_record_type),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_content_byte (rsp_content_byte),
      .rsp_token_start  (rsp_token_start),
      .rsp_last_result  (rsp_last_result)
   );

   bst_checker lex_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_type  (rsp_record_type),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_content_byte (rsp_content_byte),
      .rsp_token_start  (rsp_token_start),
      .rsp_last_result  (rsp_last_result),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   // Random idling, switched off for one long window.
   function automatic logic idle_now();
      return (cyc < QUIET_FROM || cyc >= QUIET_TO) && $urandom_range(99) < GAP_PERCENT;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0:       return CH_SPACE;
         1:       return 8'h09;
         2:       return CH_LF;
         3:       return 8'h0B;
         4:       return 8'h0C;
         default: return 8'h0D;
      endcase
   endfunction

   // Offers one transaction from a falling edge and returns at the falling edge after it is taken.
   task automatic send_char(input logic [7:0] c, input logic eoi);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_char_byte    <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // Result side: random stalls, plus one long hold-off so that the block backs up.
   initial begin : receiver
      int stall_cycles;
      stall_cycles = 0;
      forever begin
         @(negedge clock);
         stall_cycles++;
         if (stall_cycles >= HOLD_FROM && stall_cycles < HOLD_FROM + HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_now();
         end
      end
   end

   // Ends the run when neither channel has moved a transaction for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("build_script_tokenizer test failed");
      $finish;
   end

   initial begin : stimulus
      int         base;
      int         len;
      int         pick;
      logic [7:0] b;
      logic [7:0] prev;
      logic       after_word;

      after_word = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: keywords and punctuation, an identifier closed by a quote, an escaped
      // quote and a high byte inside a string, a comment of each sort, repeated end
      // markers, and an identifier closed by the end marker.
      send_text("for(in)[].=");
      send_text("Z_9\"\\\"");
      send_char(8'hFF, 1'b0);
      send_char(CH_QUOTE, 1'b0);
      send_char(CH_HASH, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(CH_LF, 1'b0);
      send_text("/**/");
      send_char(8'h0B, 1'b0);
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_text("x");
      send_char(8'h5A, 1'b1);

      // Random: well-formed script fragments with random content.
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // Identifier; two in a row need a blank between them.
            if (after_word) send_char(pick_blank(), 1'b0);
            if ($urandom_range(3) == 0) begin
               send_text(word_pool[$urandom_range(7)]);
            end else begin
               b = 8'($urandom_range(1) ? 8'h61 + $urandom_range(25)
                                        : 8'h41 + $urandom_range(25));
               send_char(b, 1'b0);
               len = $urandom_range(5);
               for (int i = 0; i < len; i++) begin
                  case ($urandom_range(3))
                     0:       b = CH_UNDER;
                     1:       b = 8'(8'h30 + $urandom_range(9));
                     2:       b = 8'(8'h41 + $urandom_range(25));
                     default: b = 8'(8'h61 + $urandom_range(25));
                  endcase
                  send_char(b, 1'b0);
               end
            end
            after_word = 1'b1;
         end else if (pick < 45) begin
            case ($urandom_range(5))
               0:       send_char(CH_DOT, 1'b0);
               1:       send_char(CH_LBRACK, 1'b0);
               2:       send_char(CH_RBRACK, 1'b0);
               3:       send_char(CH_LPAREN, 1'b0);
               4:       send_char(CH_RPAREN, 1'b0);
               default: send_char(CH_EQUALS, 1'b0);
            endcase
            after_word = 1'b0;
         end else if (pick < 60) begin
            len = 1 + $urandom_range(2);
            for (int i = 0; i < len; i++) send_char(pick_blank(), 1'b0);
            after_word = 1'b0;
         end else if (pick < 75) begin
            // String with any bytes and escapes.
            send_char(CH_QUOTE, 1'b0);
            len = $urandom_range(6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(5) == 0) begin
                  send_char(CH_BSLASH, 1'b0);
                  send_char(8'($urandom_range(255)), 1'b0);
               end else begin
                  b = 8'($urandom_range(255));
                  if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h80;
                  send_char(b, 1'b0);
               end
            end
            send_char(CH_QUOTE, 1'b0);
            after_word = 1'b0;
         end else if (pick < 85) begin
            // Line comment, closed by a line feed or now and then by the end marker.
            send_char(CH_HASH, 1'b0);
            len = $urandom_range(8);
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom_range(255));
               if (b == CH_LF) b = b ^ 8'h80;
               send_char(b, 1'b0);
            end
            if ($urandom_range(3) == 0) begin
               send_char(8'($urandom_range(255)), 1'b1);
            end else begin
               send_char(CH_LF, 1'b0);
            end
            after_word = 1'b0;
         end else if (pick < 95) begin
            // Block comment with runs of stars but no early star-slash.
            send_text("/*");
            prev = CH_STAR;
            len = $urandom_range(8);
            for (int i = 0; i < len; i++) begin
               b = ($urandom_range(3) == 0) ? CH_STAR : 8'($urandom_range(255));
               if (prev == CH_STAR && b == CH_SLASH) b = CH_STAR;
               send_char(b, 1'b0);
               prev = b;
            end
            send_text("*/");
            after_word = 1'b0;
         end else begin
            send_char(8'($urandom_range(255)), 1'b1);
            after_word = 1'b0;
         end
      end

      // Unless a digit extends an identifier, an error closes the stream and halts the block for good.
      pick = $urandom_range(7);
      case (pick)
         0, 1: begin
            if (pick == 1) send_char(8'h6B, 1'b0);
            case ($urandom_range(2))
               0:       b = 8'(8'h30 + $urandom_range(9));
               1:       b = 8'(8'h80 + $urandom_range(127));
               default: b = 8'h24;
            endcase
            send_char(b, 1'b0);
         end
         2: begin
            b = 8'($urandom_range(255));
            if (b == CH_STAR) b = CH_SLASH;
            send_char(CH_SLASH, 1'b0);
            send_char(b, 1'b0);
         end
         3: begin
            send_char(CH_SLASH, 1'b0);
            send_char(8'($urandom_range(255)), 1'b1);
         end
         4: begin
            send_text("/*ab");
            send_char(8'($urandom_range(255)), 1'b1);
         end
         5: begin
            send_text("/**");
            send_char(8'($urandom_range(255)), 1'b1);
         end
         6: begin
            send_text("\"x");
            send_char(8'($urandom_range(255)), 1'b1);
         end
         default: begin
            send_text("\"\\");
            send_char(8'($urandom_range(255)), 1'b1);
         end
      endcase

      // Transactions after an error produce nothing; the checker predicts them either way.
      for (int i = 0; i < 3; i++) begin
         send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("build_script_tokenizer test passed");
      end else begin
         $display("build_script_tokenizer test failed");
      end
      $finish;
   end

endmodule
